>>> hw/rtl/cds_pkg.sv
// Shared types and constants for the central difference slope block.
// No dependencies; compiled first.
package cds_pkg;

  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned SLOPE_W    = 17;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned RAD_W      = 33;
  localparam int unsigned PP_W       = 18;
  localparam int unsigned REM_W      = 18;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned MUL_STEPS  = 8;
  localparam int unsigned ROOT_STEPS = 17;
  localparam int unsigned MIN_SIZE   = 3;
  localparam int unsigned RST_SIZE   = 1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIFF,
    ST_MUL,
    ST_ROOT,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

endpackage

>>> hw/rtl/cds_if.sv
// Valid/ready channel interfaces for height items in and slope items out.
// Depends on cds_pkg for payload widths.
interface cds_in_if;
  logic                         valid;
  logic                         ready;
  logic [cds_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface cds_out_if;
  logic                        valid;
  logic                        ready;
  logic [cds_pkg::SLOPE_W-1:0] slope;
  logic                        last;

  modport source (output valid, output slope, output last, input ready);
  modport sink   (input valid, input slope, input last, output ready);
endinterface

>>> hw/rtl/central_difference_slope.sv
// Each interior item passes fetch, difference and load, 8 radix-4 squaring steps and 17
// root steps before its slope is in the output register; border pixels skip to a zero slope.
// One item is taken at a time; the next is accepted only once the previous one is done, so
// the square root iteration sets the pace and output stalls add to it. Row 0 emits nothing
// and the last row one extra item. Reset: synchronous active-low rst_n clears position,
// size (1024, or MAX_SIZE if smaller) and handshakes; line stores are not cleared.
module central_difference_slope #(
  parameter int unsigned MAX_SIZE = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cds_in_if.sink                    in_ch,
  cds_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [cds_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int unsigned CW = $clog2(MAX_SIZE);
  localparam int unsigned NW = $clog2(MAX_SIZE + 1);
  localparam logic [NW-1:0] N_RST =
    NW'((MAX_SIZE < cds_pkg::RST_SIZE) ? MAX_SIZE : cds_pkg::RST_SIZE);

  cds_pkg::state_t state_r, state_nxt;

  logic [NW-1:0] n_r, n_clamp, nm1;
  logic [CW-1:0] column_r, row_r;
  logic [CW-1:0] x_r;
  logic          has_out_r, comp_r, two_r, lastf_r;
  logic [cds_pkg::CNT_W-1:0] cnt_r;

  logic [cds_pkg::HEIGHT_W-1:0] h_r, above2_r;
  logic [cds_pkg::HEIGHT_W-1:0] dx_r, dy_r, sx_r, sy_r;
  logic [cds_pkg::RAD_W-1:0]    acc_r, acc_nxt;
  logic [cds_pkg::PP_W-1:0]     pp_x, pp_y;
  logic [cds_pkg::RAD_W:0]      rad_r;
  logic [cds_pkg::REM_W-1:0]    rem_r;
  logic [cds_pkg::SLOPE_W-1:0]  root_r;
  logic [cds_pkg::REM_W+1:0]    rem2, trial;
  logic                         ge;

  logic [cds_pkg::HEIGHT_W-1:0] older_mem [MAX_SIZE];
  logic [cds_pkg::HEIGHT_W-1:0] newer_mem [MAX_SIZE];
  logic [cds_pkg::HEIGHT_W-1:0] old_q, new_q;
  logic [CW-1:0]                old_ra, new_ra;
  logic                         mem_we;

  logic                         accept, out_free, out_load;
  logic                         out_valid_r, out_last_r, out_last_d;
  logic [cds_pkg::SLOPE_W-1:0]  out_slope_r, out_slope_d;
  logic [cds_pkg::HEIGHT_W-1:0] dx_d, dy_d;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign nm1      = n_r - NW'(1);

  always_comb begin
    if (32'(cfg_wr_data) > MAX_SIZE) begin
      n_clamp = NW'(MAX_SIZE);
    end else if (32'(cfg_wr_data) < cds_pkg::MIN_SIZE) begin
      n_clamp = NW'(cds_pkg::MIN_SIZE);
    end else begin
      n_clamp = NW'(cfg_wr_data);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cds_pkg::ST_IDLE: begin
        if (accept) state_nxt = cds_pkg::ST_FETCH;
      end
      cds_pkg::ST_FETCH: begin
        priority if (!has_out_r) state_nxt = cds_pkg::ST_IDLE;
        else if (!comp_r)        state_nxt = cds_pkg::ST_EMIT1;
        else                     state_nxt = cds_pkg::ST_DIFF;
      end
      cds_pkg::ST_DIFF: state_nxt = cds_pkg::ST_MUL;
      cds_pkg::ST_MUL: begin
        if (cnt_r == cds_pkg::CNT_W'(1)) state_nxt = cds_pkg::ST_ROOT;
      end
      cds_pkg::ST_ROOT: begin
        if (cnt_r == cds_pkg::CNT_W'(1)) state_nxt = cds_pkg::ST_EMIT1;
      end
      cds_pkg::ST_EMIT1: begin
        if (out_free) state_nxt = two_r ? cds_pkg::ST_EMIT2 : cds_pkg::ST_IDLE;
      end
      cds_pkg::ST_EMIT2: begin
        if (out_free) state_nxt = cds_pkg::ST_IDLE;
      end
      default: state_nxt = cds_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    out_slope_d = '0;
    out_last_d  = 1'b0;
    mem_we      = 1'b0;
    old_ra      = column_r;
    new_ra      = column_r;
    unique case (state_r)
      cds_pkg::ST_IDLE: in_ch.ready = 1'b1;
      cds_pkg::ST_FETCH: begin
        mem_we = 1'b1;
        old_ra = x_r - CW'(1);
        new_ra = x_r + CW'(1);
      end
      cds_pkg::ST_EMIT1: begin
        out_load    = out_free;
        out_slope_d = comp_r ? root_r : '0;
      end
      cds_pkg::ST_EMIT2: begin
        out_load   = out_free;
        out_last_d = lastf_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      older_mem[x_r] <= new_q;
      newer_mem[x_r] <= h_r;
    end
    old_q <= older_mem[old_ra];
    new_q <= newer_mem[new_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cds_pkg::ST_IDLE;
      n_r         <= N_RST;
      column_r    <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        n_r      <= n_clamp;
        column_r <= '0;
        row_r    <= '0;
      end else if (accept) begin
        if (NW'(column_r) == nm1) begin
          column_r <= '0;
          row_r    <= (NW'(row_r) == nm1) ? '0 : row_r + CW'(1);
        end else begin
          column_r <= column_r + CW'(1);
        end
      end
      priority if (state_r == cds_pkg::ST_DIFF) begin
        cnt_r <= cds_pkg::CNT_W'(cds_pkg::MUL_STEPS);
      end else if (state_r == cds_pkg::ST_MUL && cnt_r == cds_pkg::CNT_W'(1)) begin
        cnt_r <= cds_pkg::CNT_W'(cds_pkg::ROOT_STEPS);
      end else if (state_r == cds_pkg::ST_MUL || state_r == cds_pkg::ST_ROOT) begin
        cnt_r <= cnt_r - cds_pkg::CNT_W'(1);
      end else begin
        cnt_r <= cnt_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Radix-4 squaring, most significant digit first
  assign pp_x = (sx_r[15] ? {1'b0, dx_r, 1'b0} : '0) + (sx_r[14] ? {2'b0, dx_r} : '0);
  assign pp_y = (sy_r[15] ? {1'b0, dy_r, 1'b0} : '0) + (sy_r[14] ? {2'b0, dy_r} : '0);
  assign acc_nxt = {acc_r[cds_pkg::RAD_W-3:0], 2'b00} + cds_pkg::RAD_W'(pp_x)
                 + cds_pkg::RAD_W'(pp_y);

  // Bit-serial square root, two radicand bits per step
  assign rem2  = {rem_r, rad_r[cds_pkg::RAD_W:cds_pkg::RAD_W-1]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = rem2 >= trial;

  assign dx_d = (new_q >= old_q) ? new_q - old_q : old_q - new_q;
  assign dy_d = (h_r >= above2_r) ? h_r - above2_r : above2_r - h_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      h_r       <= in_ch.height;
      x_r       <= column_r;
      has_out_r <= row_r != '0;
      comp_r    <= (column_r != '0) && (NW'(column_r) != nm1) && (row_r > CW'(1));
      two_r     <= NW'(row_r) == nm1;
      lastf_r   <= NW'(column_r) == nm1;
    end
    if (state_r == cds_pkg::ST_FETCH) begin
      above2_r <= old_q;
    end
    if (state_r == cds_pkg::ST_DIFF) begin
      dx_r  <= dx_d;
      dy_r  <= dy_d;
      sx_r  <= dx_d;
      sy_r  <= dy_d;
      acc_r <= '0;
    end
    if (state_r == cds_pkg::ST_MUL) begin
      acc_r <= acc_nxt;
      sx_r  <= {sx_r[13:0], 2'b00};
      sy_r  <= {sy_r[13:0], 2'b00};
      if (cnt_r == cds_pkg::CNT_W'(1)) begin
        rad_r  <= {1'b0, acc_nxt};
        rem_r  <= '0;
        root_r <= '0;
      end
    end
    if (state_r == cds_pkg::ST_ROOT) begin
      rem_r  <= ge ? cds_pkg::REM_W'(rem2 - trial) : cds_pkg::REM_W'(rem2);
      root_r <= {root_r[cds_pkg::SLOPE_W-2:0], ge};
      rad_r  <= {rad_r[cds_pkg::RAD_W-2:0], 2'b00};
    end
    if (out_load) begin
      out_slope_r <= out_slope_d;
      out_last_r  <= out_last_d;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.slope = out_slope_r;
  assign out_ch.last  = out_last_r;

`ifndef NO_ASSERTIONS
  a_column_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    NW'(column_r) < n_r)
    else $error("column beyond map size");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("item accepted while another is in flight");

  a_root_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cds_pkg::ST_EMIT1 && comp_r) |->
      ({1'b0, rem_r} <= {root_r, 1'b0}))
    else $error("square root remainder out of bound");

  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (out_ch.slope == '0))
    else $error("frame end carries nonzero slope");

  a_root_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cds_pkg::ST_MUL && state_nxt == cds_pkg::ST_ROOT) |=>
      (cnt_r == cds_pkg::CNT_W'(cds_pkg::ROOT_STEPS)))
    else $error("root iteration count not loaded");
`endif

endmodule
